/* sv/swsal_pkg.sv */
package swsal_pkg;

  localparam int THR_W = 27;  // threshold register width
  localparam int VAL_W = 14;  // value field width
  localparam int LEN_W = 18;  // min_length field width

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             is_last;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] min_length;
    logic             overflow;
  } out_item_t;

endpackage

/* sv/shortest_window_sum_at_least.sv */
// Shortest window whose running sum reaches a threshold, over a stream of values.
//
// Input channel (in_valid/in_ready/in_data): one value per item, is_last marks the
// final value of a sequence. Result channel (out_valid/out_ready/out_data): one item
// per sequence, sent after its last value, carrying the shortest qualifying window
// length (0 if none) and a flag set when a window outgrew the store.
// cfg_we/cfg_wdata write the threshold; write it only while idle.
//
// Timing: an item is pushed in S_IDLE, then S_POP drops values from the front of
// the window one at a time while the sum still qualifies, and S_DONE loads the
// result for a last item. Each value is pushed once and dropped at most once.
// No new item is taken in S_POP or S_DONE. The window store is a single memory
// with one write port and one registered read port; the read runs ahead on the
// next head address and a same-cycle write to that entry is forwarded.
//
// Reset (rst_n low, synchronous) empties the window, clears the result slot and
// sets the threshold to 1. The store itself is never cleared: only written entries
// are read. A result waits in the output register while the receiver stalls; new
// items are still taken, and the block only holds off at the end of the next
// sequence until the slot is free.
module shortest_window_sum_at_least #(
  parameter int MAX_WINDOW = 131072,
  parameter int VALUE_BITS = 14
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  swsal_pkg::in_item_t      in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output swsal_pkg::out_item_t     out_data,
  input  logic                     cfg_we,
  input  logic [swsal_pkg::THR_W-1:0] cfg_wdata
);
  import swsal_pkg::*;

  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = ((THR_W > VALUE_BITS) ? THR_W : VALUE_BITS) + 1;

  typedef enum logic [1:0] {
    S_IDLE,  // waiting for a value
    S_POP,   // dropping the oldest value while the sum still qualifies
    S_DONE   // last value handled, load the result
  } state_t;

  // window store
  logic [VALUE_BITS-1:0] mem [MAX_WINDOW];

  state_t              state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CW-1:0]       best_r, best_nxt;
  logic                ovf_r, ovf_nxt;
  logic                last_r, last_nxt;
  logic [THR_W-1:0]    thr_r;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic [VALUE_BITS-1:0] rdata_r;
  logic                fwd_r;
  logic [VALUE_BITS-1:0] fwd_data_r;

  logic                  accept;
  logic                  we;
  logic                  full;
  logic [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0] old_val;
  logic [SUM_W-1:0]      sum_thr;
  logic [SUM_W-1:0]      push_sum;
  logic [CW-1:0]         push_cnt;
  logic [SUM_W-1:0]      pop_sum;
  logic [CW-1:0]         pop_cnt;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] pos);
    advance = (pos == AW'(MAX_WINDOW - 1)) ? '0 : pos + AW'(1);
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign v        = VALUE_BITS'(in_data.value);
  assign full     = (count_r == CW'(MAX_WINDOW));
  // oldest value; the read data is for head_r, patched if it was written last cycle
  assign old_val  = fwd_r ? fwd_data_r : rdata_r;
  assign sum_thr  = SUM_W'(thr_r);
  // when the store is full the oldest value is evicted as the new one goes in
  assign push_sum = (sum_r - (full ? SUM_W'(old_val) : '0)) + SUM_W'(v);
  assign push_cnt = full ? count_r : count_r + CW'(1);
  assign pop_sum  = sum_r - SUM_W'(old_val);
  assign pop_cnt  = count_r - CW'(1);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    best_nxt      = best_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          we        = 1'b1;
          tail_nxt  = advance(tail_r);
          head_nxt  = full ? advance(head_r) : head_r;
          ovf_nxt   = ovf_r | full;
          sum_nxt   = push_sum;
          count_nxt = push_cnt;
          last_nxt  = in_data.is_last;
          if (push_sum >= sum_thr) begin
            if (best_r == '0 || push_cnt < best_r) begin
              best_nxt = push_cnt;
            end
            state_nxt = S_POP;
          end else begin
            state_nxt = in_data.is_last ? S_DONE : S_IDLE;
          end
        end
      end
      S_POP: begin
        head_nxt  = advance(head_r);
        sum_nxt   = pop_sum;
        count_nxt = pop_cnt;
        if (pop_cnt != '0 && pop_sum >= sum_thr) begin
          if (best_r == '0 || pop_cnt < best_r) begin
            best_nxt = pop_cnt;
          end
        end else begin
          state_nxt = last_r ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.min_length = LEN_W'(best_r);
          out_data_nxt.overflow   = ovf_r;
          head_nxt  = '0;
          tail_nxt  = '0;
          count_nxt = '0;
          sum_nxt   = '0;
          best_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      best_r      <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      thr_r       <= THR_RESET;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      best_r      <= best_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_r       <= we && (tail_r == head_nxt);
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    fwd_data_r <= v;
  end

  // store: one write, one registered read that tracks the next head
  always_ff @(posedge clk) begin
    if (we) begin
      mem[tail_r] <= v;
    end
    rdata_r <= mem[head_nxt];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_WINDOW))
    else $error("window count above store size");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |-> count_r != '0)
    else $error("drop from empty window");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_ready))
      |=> out_valid_r && count_r == '0 && state_r == S_IDLE)
    else $error("result not loaded or window not cleared");

  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CW'(MAX_WINDOW)) |-> head_r == tail_r)
    else $error("head and tail disagree with count");

endmodule
